// File: hw/rtl/mmt_pkg.sv
// Shared types, codes and helpers of the Modbus master transaction controller.
package mmt_pkg;

    // Event kinds.
    localparam logic [1:0] FUNC_SUBMIT = 2'd0;
    localparam logic [1:0] FUNC_POLL   = 2'd1;
    localparam logic [1:0] FUNC_RESET  = 2'd2;

    // Submit return codes.
    localparam logic [2:0] RC_OK       = 3'd0;
    localparam logic [2:0] RC_INVALID  = 3'd1;
    localparam logic [2:0] RC_BUSY     = 3'd2;
    localparam logic [2:0] RC_SEND_ERR = 3'd3;
    localparam logic [2:0] RC_NONE     = 3'd4;

    // Last status codes.
    localparam logic [2:0] LS_OK       = 3'd0;
    localparam logic [2:0] LS_TXFAIL   = 3'd1;
    localparam logic [2:0] LS_TIMEOUT  = 3'd2;
    localparam logic [2:0] LS_SENDERR  = 3'd3;
    localparam logic [2:0] LS_RELERR   = 3'd4;

    // Transmit and parse outcomes.
    localparam logic [1:0] TXR_DONE    = 2'd1;
    localparam logic [1:0] TXR_FAIL    = 2'd2;
    localparam logic [1:0] PR_OK       = 2'd0;
    localparam logic [1:0] PR_EXC      = 2'd1;

    // Reported state codes.
    localparam logic [3:0] SC_IDLE    = 4'd0;
    localparam logic [3:0] SC_TX      = 4'd1;
    localparam logic [3:0] SC_BCAST   = 4'd2;
    localparam logic [3:0] SC_WAIT    = 4'd3;
    localparam logic [3:0] SC_DONE    = 4'd4;
    localparam logic [3:0] SC_TIMEOUT = 4'd5;
    localparam logic [3:0] SC_TERR    = 4'd6;
    localparam logic [3:0] SC_EXC     = 4'd7;
    localparam logic [3:0] SC_PERR    = 4'd8;

    localparam logic [8:0] MIN_REQ_LEN = 9'd4;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_TX      = 9'b000000010,
        S_BCAST   = 9'b000000100,
        S_WAIT    = 9'b000001000,
        S_DONE    = 9'b000010000,
        S_TIMEOUT = 9'b000100000,
        S_TERR    = 9'b001000000,
        S_EXC     = 9'b010000000,
        S_PERR    = 9'b100000000
    } t_fsm;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] current_tick;
        logic [31:0] timeout_ticks;
        logic [8:0]  request_length;
        logic [7:0]  request_address;
        logic        uart_busy;
        logic        send_ok;
        logic [1:0]  tx_result;
        logic        frame_ready;
        logic [1:0]  parse_result;
        logic        release_ok;
    } t_item;

    typedef struct packed {
        t_fsm        state;
        logic [31:0] start_tick;
        logic [31:0] timeout_limit;
        logic [2:0]  last_status;
        logic [31:0] completed;
        logic [31:0] timeouts;
        logic [31:0] transport_errors;
        logic [31:0] protocol_errors;
    } t_ctx;

    typedef struct packed {
        logic [2:0]  return_code;
        logic [3:0]  fsm_state;
        logic        finished;
        logic [2:0]  last_status;
        logic        abort_receive;
        logic [31:0] completed_total;
        logic [31:0] timeout_total;
        logic [31:0] transport_error_total;
        logic [31:0] protocol_error_total;
    } t_result;

    function automatic logic [3:0] state_code(input t_fsm s);
        logic [3:0] code;
        case (s)
            S_IDLE:    code = SC_IDLE;
            S_TX:      code = SC_TX;
            S_BCAST:   code = SC_BCAST;
            S_WAIT:    code = SC_WAIT;
            S_DONE:    code = SC_DONE;
            S_TIMEOUT: code = SC_TIMEOUT;
            S_TERR:    code = SC_TERR;
            S_EXC:     code = SC_EXC;
            S_PERR:    code = SC_PERR;
            default:   code = SC_IDLE;
        endcase
        return code;
    endfunction

endpackage

// File: hw/rtl/mmt_step.sv
// Combinational next-state and result logic for one event.
module mmt_step (
    input  mmt_pkg::t_ctx    i_ctx,
    input  mmt_pkg::t_item   i_item,
    output mmt_pkg::t_ctx    o_ctx,
    output mmt_pkg::t_result o_res
);

    logic [31:0] elapsed;
    logic        timed_out;
    logic        busy_state;
    logic [2:0]  return_code;
    logic        abort_rx;
    logic        is_final;

    assign elapsed    = i_item.current_tick - i_ctx.start_tick;
    assign timed_out  = elapsed >= i_ctx.timeout_limit;
    assign busy_state = (i_ctx.state == mmt_pkg::S_TX) || (i_ctx.state == mmt_pkg::S_BCAST) ||
                        (i_ctx.state == mmt_pkg::S_WAIT);

    always_comb begin
        o_ctx       = i_ctx;
        return_code = mmt_pkg::RC_NONE;
        abort_rx    = 1'b0;
        case (i_item.func)
            mmt_pkg::FUNC_SUBMIT: begin
                if (i_item.request_length < mmt_pkg::MIN_REQ_LEN ||
                    i_item.timeout_ticks == 32'd0) begin
                    return_code = mmt_pkg::RC_INVALID;
                end else if (busy_state || i_item.uart_busy) begin
                    return_code = mmt_pkg::RC_BUSY;
                end else if (!i_item.send_ok) begin
                    o_ctx.last_status      = mmt_pkg::LS_SENDERR;
                    o_ctx.transport_errors = i_ctx.transport_errors + 32'd1;
                    o_ctx.state            = mmt_pkg::S_TERR;
                    return_code            = mmt_pkg::RC_SEND_ERR;
                end else begin
                    o_ctx.last_status   = mmt_pkg::LS_OK;
                    o_ctx.start_tick    = i_item.current_tick;
                    o_ctx.timeout_limit = i_item.timeout_ticks;
                    o_ctx.state         = (i_item.request_address == 8'd0) ?
                                          mmt_pkg::S_BCAST : mmt_pkg::S_TX;
                    return_code         = mmt_pkg::RC_OK;
                end
            end
            mmt_pkg::FUNC_POLL: begin
                case (i_ctx.state)
                    mmt_pkg::S_TX, mmt_pkg::S_BCAST: begin
                        if (i_item.tx_result == mmt_pkg::TXR_FAIL) begin
                            o_ctx.last_status      = mmt_pkg::LS_TXFAIL;
                            o_ctx.transport_errors = i_ctx.transport_errors + 32'd1;
                            o_ctx.state            = mmt_pkg::S_TERR;
                            abort_rx               = 1'b1;
                        end else if (i_item.tx_result == mmt_pkg::TXR_DONE) begin
                            if (i_ctx.state == mmt_pkg::S_BCAST) begin
                                o_ctx.state     = mmt_pkg::S_DONE;
                                o_ctx.completed = i_ctx.completed + 32'd1;
                            end else begin
                                // The response timeout runs from the end of transmission.
                                o_ctx.start_tick = i_item.current_tick;
                                o_ctx.state      = mmt_pkg::S_WAIT;
                            end
                        end else if (timed_out) begin
                            o_ctx.last_status = mmt_pkg::LS_TIMEOUT;
                            o_ctx.timeouts    = i_ctx.timeouts + 32'd1;
                            o_ctx.state       = mmt_pkg::S_TIMEOUT;
                            abort_rx          = 1'b1;
                        end
                    end
                    mmt_pkg::S_WAIT: begin
                        if (i_item.frame_ready) begin
                            if (!i_item.release_ok) begin
                                o_ctx.last_status      = mmt_pkg::LS_RELERR;
                                o_ctx.transport_errors = i_ctx.transport_errors + 32'd1;
                                o_ctx.state            = mmt_pkg::S_TERR;
                            end else begin
                                o_ctx.last_status = mmt_pkg::LS_OK;
                                if (i_item.parse_result == mmt_pkg::PR_OK) begin
                                    o_ctx.completed = i_ctx.completed + 32'd1;
                                    o_ctx.state     = mmt_pkg::S_DONE;
                                end else if (i_item.parse_result == mmt_pkg::PR_EXC) begin
                                    o_ctx.state = mmt_pkg::S_EXC;
                                end else begin
                                    o_ctx.protocol_errors = i_ctx.protocol_errors + 32'd1;
                                    o_ctx.state           = mmt_pkg::S_PERR;
                                end
                            end
                        end else if (timed_out) begin
                            o_ctx.last_status = mmt_pkg::LS_TIMEOUT;
                            o_ctx.timeouts    = i_ctx.timeouts + 32'd1;
                            o_ctx.state       = mmt_pkg::S_TIMEOUT;
                            abort_rx          = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            mmt_pkg::FUNC_RESET: begin
                o_ctx.state = mmt_pkg::S_IDLE;
            end
            default: begin
            end
        endcase
    end

    assign is_final = (o_ctx.state == mmt_pkg::S_DONE) || (o_ctx.state == mmt_pkg::S_TIMEOUT) ||
                      (o_ctx.state == mmt_pkg::S_TERR) || (o_ctx.state == mmt_pkg::S_EXC) ||
                      (o_ctx.state == mmt_pkg::S_PERR);

    assign o_res.return_code           = return_code;
    assign o_res.fsm_state             = mmt_pkg::state_code(o_ctx.state);
    assign o_res.finished              = is_final;
    assign o_res.last_status           = o_ctx.last_status;
    assign o_res.abort_receive         = abort_rx;
    assign o_res.completed_total       = o_ctx.completed;
    assign o_res.timeout_total         = o_ctx.timeouts;
    assign o_res.transport_error_total = o_ctx.transport_errors;
    assign o_res.protocol_error_total  = o_ctx.protocol_errors;

endmodule

// File: hw/rtl/mmt_state.sv
// Transaction state and counter registers, advanced by one event per enabled cycle.
module mmt_state (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  mmt_pkg::t_item   i_item,
    output mmt_pkg::t_result o_res
);

    mmt_pkg::t_ctx r_ctx;
    mmt_pkg::t_ctx n_ctx;

    mmt_step u_step (
        .i_ctx  (r_ctx),
        .i_item (i_item),
        .o_ctx  (n_ctx),
        .o_res  (o_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx.state            <= mmt_pkg::S_IDLE;
            r_ctx.start_tick       <= 32'd0;
            r_ctx.timeout_limit    <= 32'd0;
            r_ctx.last_status      <= mmt_pkg::LS_OK;
            r_ctx.completed        <= 32'd0;
            r_ctx.timeouts         <= 32'd0;
            r_ctx.transport_errors <= 32'd0;
            r_ctx.protocol_errors  <= 32'd0;
        end else if (i_en) begin
            r_ctx <= n_ctx;
        end
    end

endmodule

// File: hw/rtl/modbus_master_transaction_fsm.sv
// An accepted word is held in the input register; its result is then registered in the output register.
// Throughput: one event word per cycle while the output is not stalled; the state update is a single 32-bit
// subtract-and-compare plus counter increments between the input and output registers.
// Reset (synchronous, active low) empties both registers, returns the machine to
// idle and clears the start tick, the timeout, the last status and all four counters.
module modbus_master_transaction_fsm (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_current_tick,
    input  logic [31:0] i_timeout_ticks,
    input  logic [8:0]  i_request_length,
    input  logic [7:0]  i_request_address,
    input  logic        i_uart_busy,
    input  logic        i_send_ok,
    input  logic [1:0]  i_tx_result,
    input  logic        i_frame_ready,
    input  logic [1:0]  i_parse_result,
    input  logic        i_release_ok,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_return_code,
    output logic [3:0]  o_fsm_state,
    output logic        o_finished,
    output logic [2:0]  o_last_status,
    output logic        o_abort_receive,
    output logic [31:0] o_completed_total,
    output logic [31:0] o_timeout_total,
    output logic [31:0] o_transport_error_total,
    output logic [31:0] o_protocol_error_total
);

    logic             r_in_valid;
    mmt_pkg::t_item   r_item;
    logic             r_out_valid;
    mmt_pkg::t_result r_res;
    mmt_pkg::t_result step_res;
    logic             advance;
    logic             in_take;

    // The held word moves on whenever the output register is empty or being drained.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.func            <= i_func;
            r_item.current_tick    <= i_current_tick;
            r_item.timeout_ticks   <= i_timeout_ticks;
            r_item.request_length  <= i_request_length;
            r_item.request_address <= i_request_address;
            r_item.uart_busy       <= i_uart_busy;
            r_item.send_ok         <= i_send_ok;
            r_item.tx_result       <= i_tx_result;
            r_item.frame_ready     <= i_frame_ready;
            r_item.parse_result    <= i_parse_result;
            r_item.release_ok      <= i_release_ok;
        end
    end

    mmt_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_item  (r_item),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= step_res;
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_return_code           = r_res.return_code;
    assign o_fsm_state             = r_res.fsm_state;
    assign o_finished              = r_res.finished;
    assign o_last_status           = r_res.last_status;
    assign o_abort_receive         = r_res.abort_receive;
    assign o_completed_total       = r_res.completed_total;
    assign o_timeout_total         = r_res.timeout_total;
    assign o_transport_error_total = r_res.transport_error_total;
    assign o_protocol_error_total  = r_res.protocol_error_total;

endmodule

// File: hw/rtl/mmt_checker.sv
// Port-level checks of the transaction controller, bound to its top level.
module mmt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_return_code,
    input logic [3:0]  o_fsm_state,
    input logic        o_finished,
    input logic [2:0]  o_last_status,
    input logic        o_abort_receive,
    input logic [31:0] o_completed_total
);

    // Nothing is shown on the output in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid right after reset");

    // The finished flag follows the reported state.
    a_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_finished == (o_fsm_state >= mmt_pkg::SC_DONE)))
        else $error("finished flag disagrees with state");

    // An abort request only comes from a poll that ends in a timeout or a transmit failure.
    a_abort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_abort_receive) |->
            (o_return_code == mmt_pkg::RC_NONE) &&
            ((o_fsm_state == mmt_pkg::SC_TIMEOUT && o_last_status == mmt_pkg::LS_TIMEOUT) ||
             (o_fsm_state == mmt_pkg::SC_TERR && o_last_status == mmt_pkg::LS_TXFAIL)))
        else $error("abort request without a timeout or transmit failure");

    // A stalled output word stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_completed_total)))
        else $error("stalled output word changed");

endmodule

bind modbus_master_transaction_fsm mmt_checker u_mmt_checker (.*);
